/* src/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// Shared word types and constants for the point-to-screen projection block.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int NUM_REGS  = 8;
  localparam int CFG_AW    = 6;   // 8 registers at 8-byte spacing
  localparam int REG_W     = 64;
  localparam int QUO_BITS  = 41;  // ratio clamps at 2^40 LSB

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    64'h0000_0001_0000_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  typedef logic [NUM_REGS-1:0][REG_W-1:0] matrix_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [15:0] extent_x;
    logic        [15:0] extent_y;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] clip_z;
    logic signed [31:0] clip_w;
    logic               range_flag;
  } out_word_t;

  // Clip values and viewport fields that ride along the divider.
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] cw;
    logic               flag;
    logic        [15:0] ex;
    logic        [15:0] ey;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
  } side_t;

endpackage

/* src/pps_matrix.sv */
// ----------------------------------------------------------------------------
// pps_matrix
// Three-stage 4x4 matrix times (x,y,z,1): products, rounded row sums, clamp.
// ----------------------------------------------------------------------------
module pps_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  pps_pkg::in_word_t in_data,
  input  pps_pkg::matrix_t  mat,
  output logic              out_valid,
  output pps_pkg::side_t    out_side
);
  import pps_pkg::*;

  localparam int SUM_W = 66;
  localparam logic signed [SUM_W-1:0] MAXV = 66'sd2147483647;
  localparam logic signed [SUM_W-1:0] MINV = -66'sd2147483648;
  localparam logic signed [SUM_W-1:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0]      prod_r   [4][4];
  logic signed [63:0]      prod_nxt [4][4];
  logic signed [SUM_W-1:0] sum_r    [4];
  logic signed [SUM_W-1:0] sum_nxt  [4];
  logic signed [31:0]      clip_nxt [4];
  logic                    sat_nxt;
  in_word_t                word_a_r, word_b_r;
  logic                    va_r, vb_r, vc_r;
  side_t                   side_r;

  always_comb begin
    logic signed [31:0] ent;
    logic signed [31:0] pos;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ent = mat[r*2 + (c >> 1)][(c & 1)*32 +: 32];
        pos = (c == 0) ? in_data.pos_x : (c == 1) ? in_data.pos_y : in_data.pos_z;
        if (c == 3) begin
          prod_nxt[r][c] = 64'(ent) <<< FRAC_BITS;
        end else begin
          prod_nxt[r][c] = ent * pos;
        end
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_nxt[r] = (SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]) + SUM_W'(prod_r[r][2])
                   + SUM_W'(prod_r[r][3]) + HALF) >>> FRAC_BITS;
    end
  end

  always_comb begin
    sat_nxt = 1'b0;
    for (int r = 0; r < 4; r++) begin
      if (sum_r[r] > MAXV) begin
        clip_nxt[r] = 32'sh7fff_ffff;
        sat_nxt     = 1'b1;
      end else if (sum_r[r] < MINV) begin
        clip_nxt[r] = 32'sh8000_0000;
        sat_nxt     = 1'b1;
      end else begin
        clip_nxt[r] = 32'(sum_r[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      word_a_r <= in_data;
      sum_r    <= sum_nxt;
      word_b_r <= word_a_r;
      side_r.cx   <= clip_nxt[0];
      side_r.cy   <= clip_nxt[1];
      side_r.cz   <= clip_nxt[2];
      side_r.cw   <= clip_nxt[3];
      side_r.flag <= sat_nxt || (clip_nxt[3] == 32'sd0);
      side_r.ex   <= word_b_r.extent_x;
      side_r.ey   <= word_b_r.extent_y;
      side_r.ox   <= word_b_r.offset_x;
      side_r.oy   <= word_b_r.offset_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  assign out_valid = vc_r;
  assign out_side  = side_r;

endmodule

/* src/pps_divider.sv */
// ----------------------------------------------------------------------------
// pps_divider
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// the divisor 2|w|; rounds to nearest, clamps to +-2^40, applies sign.
// ----------------------------------------------------------------------------
module pps_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  pps_pkg::side_t                in_side,
  output logic                          out_valid,
  output pps_pkg::side_t                out_side,
  output logic signed [pps_pkg::QUO_BITS:0] out_nx,
  output logic signed [pps_pkg::QUO_BITS:0] out_ny
);
  import pps_pkg::*;

  localparam int QB = QUO_BITS;
  localparam int DW = 35 + QB;
  localparam logic [QB-1:0] CLAMP = QB'(1) << (QB - 1);

  logic [DW-1:0] remx_r [QB+1];
  logic [DW-1:0] remy_r [QB+1];
  logic [DW-1:0] den_r  [QB+1];
  logic [QB-1:0] qx_r   [QB+1];
  logic [QB-1:0] qy_r   [QB+1];
  logic          ovx_r  [QB+1];
  logic          ovy_r  [QB+1];
  side_t         side_r [QB+1];
  logic          v_r    [QB+1];

  logic [32:0]   ax, ay, aw;
  logic [DW-1:0] nx_num, ny_num, den;

  logic signed [QB:0] nx_r, ny_r;
  side_t              side_o_r;
  logic               v_o_r;

  function automatic logic [32:0] mag(input logic signed [31:0] v);
    logic signed [32:0] e;
    e = 33'(v);
    return (e < 0) ? 33'(-e) : 33'(e);
  endfunction

  // Rounded magnitude with clamp, sign and the zero-w case.
  function automatic logic signed [QB:0] finish(input logic [QB-1:0] q, input logic ov,
                                                input logic signed [31:0] c,
                                                input logic wz);
    logic [QB-1:0] m;
    if (wz) begin
      m = (c == 32'sd0) ? '0 : CLAMP;
    end else if (ov || (q > CLAMP)) begin
      m = CLAMP;
    end else begin
      m = q;
    end
    return (c < 0) ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  always_comb begin
    ax     = mag(in_side.cx);
    ay     = mag(in_side.cy);
    aw     = mag(in_side.cw);
    nx_num = (DW'(ax) << FRAC_BITS) + DW'(aw);
    ny_num = (DW'(ay) << FRAC_BITS) + DW'(aw);
    den    = DW'(aw) << 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      remx_r[0] <= nx_num;
      remy_r[0] <= ny_num;
      den_r[0]  <= den;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      ovx_r[0]  <= nx_num >= (den << QB);
      ovy_r[0]  <= ny_num >= (den << QB);
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    localparam int SH = QB - 1 - k;
    logic [DW-1:0] dsh;
    logic          gex, gey;
    assign dsh = den_r[k] << SH;
    assign gex = remx_r[k] >= dsh;
    assign gey = remy_r[k] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        remx_r[k+1] <= gex ? remx_r[k] - dsh : remx_r[k];
        remy_r[k+1] <= gey ? remy_r[k] - dsh : remy_r[k];
        qx_r[k+1]   <= qx_r[k] | (QB'(gex) << SH);
        qy_r[k+1]   <= qy_r[k] | (QB'(gey) << SH);
        den_r[k+1]  <= den_r[k];
        ovx_r[k+1]  <= ovx_r[k];
        ovy_r[k+1]  <= ovy_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r     <= finish(qx_r[QB], ovx_r[QB], side_r[QB].cx, side_r[QB].cw == 32'sd0);
      ny_r     <= finish(qy_r[QB], ovy_r[QB], side_r[QB].cy, side_r[QB].cw == 32'sd0);
      side_o_r <= side_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
      v_o_r  <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      v_o_r  <= v_r[QB];
    end
  end

  assign out_valid = v_o_r;
  assign out_side  = side_o_r;
  assign out_nx    = nx_r;
  assign out_ny    = ny_r;

endmodule

/* src/pps_viewport.sv */
// ----------------------------------------------------------------------------
// pps_viewport
// Bias and flip, scale by extent, add offset and saturate into the output word.
// ----------------------------------------------------------------------------
module pps_viewport #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  pps_pkg::side_t                    in_side,
  input  logic signed [pps_pkg::QUO_BITS:0] in_nx,
  input  logic signed [pps_pkg::QUO_BITS:0] in_ny,
  output logic                              out_valid,
  output pps_pkg::out_word_t                out_data
);
  import pps_pkg::*;

  localparam int NW = QUO_BITS + 2;
  localparam int PW = NW + 17;
  localparam logic signed [NW-1:0] HALF = NW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [63:0]   MAXV = 64'sd2147483647;
  localparam logic signed [63:0]   MINV = -64'sd2147483648;

  logic signed [NW-1:0] bx_r, by_r;
  logic signed [PW-1:0] px_r, py_r;
  side_t                side1_r, side2_r;
  logic                 v1_r, v2_r, v3_r;
  out_word_t            word_r;
  logic signed [63:0]   sx, sy;
  logic                 satx, saty;
  logic signed [31:0]   sx32, sy32;

  always_comb begin
    sx = 64'(px_r) + (64'(side2_r.ox) <<< FRAC_BITS);
    sy = 64'(py_r) + (64'(side2_r.oy) <<< FRAC_BITS);
    satx = (sx > MAXV) || (sx < MINV);
    saty = (sy > MAXV) || (sy < MINV);
    sx32 = (sx > MAXV) ? 32'sh7fff_ffff : (sx < MINV) ? 32'sh8000_0000 : 32'(sx);
    sy32 = (sy > MAXV) ? 32'sh7fff_ffff : (sy < MINV) ? 32'sh8000_0000 : 32'(sy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bx_r    <= NW'(in_nx) + HALF;
      by_r    <= HALF - NW'(in_ny);
      side1_r <= in_side;
      px_r    <= bx_r * $signed({1'b0, side1_r.ex});
      py_r    <= by_r * $signed({1'b0, side1_r.ey});
      side2_r <= side1_r;
      word_r.screen_x   <= sx32;
      word_r.screen_y   <= sy32;
      word_r.clip_z     <= side2_r.cz;
      word_r.clip_w     <= side2_r.cw;
      word_r.range_flag <= side2_r.flag || satx || saty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = word_r;

endmodule

/* src/point_project_to_screen.sv */
// ----------------------------------------------------------------------------
// point_project_to_screen
// World point to viewport pixels through a configurable 4x4 matrix.
// ----------------------------------------------------------------------------
// One point enters per clock unless the pipe holds; its result passes through
// three stages of matrix products and rounded row sums, one divider setup
// stage, one stage per quotient bit of the 41-bit restoring divider, one clamp
// stage and three viewport stages, the last being the output register.
// The whole pipe advances together; it holds while a result sits stalled at
// the output, and in_stall reports exactly that. Matrix registers sit on an
// APB port at 8*i, 64 bits wide, and should be written while the pipe is
// empty. Outputs: screen x/y (Q, y flipped), undivided clip z and w, and
// range_flag for w == 0 or any saturation.
// ----------------------------------------------------------------------------
module point_project_to_screen #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pps_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pps_pkg::out_word_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pps_pkg::CFG_AW-1:0]    paddr,
  input  logic [pps_pkg::REG_W-1:0]     pwdata,
  output logic [pps_pkg::REG_W-1:0]     prdata,
  output logic                          pready
);
  import pps_pkg::*;

  matrix_t mat_r;
  logic    en;
  logic    mv, dv;
  side_t   m_side, d_side;
  logic signed [QUO_BITS:0] nx, ny;
  logic [2:0] widx;

  // Global advance: freeze only while the output word is held.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign pready = 1'b1;
  assign widx   = paddr[CFG_AW-1:3];
  assign prdata = mat_r[widx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        mat_r[i] <= REG_RESET[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      mat_r[widx] <= pwdata;
    end
  end

  pps_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk, .rst_n, .en,
    .in_valid, .in_data, .mat(mat_r),
    .out_valid(mv), .out_side(m_side)
  );

  pps_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
    .clk, .rst_n, .en,
    .in_valid(mv), .in_side(m_side),
    .out_valid(dv), .out_side(d_side), .out_nx(nx), .out_ny(ny)
  );

  pps_viewport #(.FRAC_BITS(FRAC_BITS)) u_viewport (
    .clk, .rst_n, .en,
    .in_valid(dv), .in_side(d_side), .in_nx(nx), .in_ny(ny),
    .out_valid, .out_data
  );

endmodule

/* src/pps_checker.sv */
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks for point_project_to_screen, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input pps_pkg::in_word_t          in_data,
  input logic                       out_valid,
  input logic                       out_stall,
  input pps_pkg::out_word_t         out_data,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [pps_pkg::CFG_AW-1:0] paddr,
  input logic [pps_pkg::REG_W-1:0]  pwdata,
  input logic [pps_pkg::REG_W-1:0]  prdata,
  input logic                       pready
);
  import pps_pkg::*;

  // A held word stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // A held word keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("output word changed while stalled");

  // Input stalls only behind a held output word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // Register readback returns the last write.
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready |=>
      (paddr != $past(paddr)) || (prdata == $past(pwdata)))
    else $error("register readback mismatch");

endmodule

bind point_project_to_screen pps_checker u_pps_checker (.*);

/* tb/sv/point_project_to_screen_tb.sv */
// ----------------------------------------------------------------------------
// point_project_to_screen_tb
// Self-checking bench for the point-to-screen projection pipe: directed
// corner points, random matrices and points, random idling on both sides and
// one long output hold-off. Each result is checked against a local predictor.
// ----------------------------------------------------------------------------
module point_project_to_screen_tb;
  import pps_pkg::*;

  localparam int FRAC      = 16;
  localparam int PIPE_LAT  = 49;
  localparam int CYCLE_CAP = 400000;
  localparam logic signed [63:0] RATIO_CLAMP = 64'sd1 << 40;

  // register indexes
  typedef enum int {
    R0A = 0, R0B = 1, R1A = 2, R1B = 3, R2A = 4, R2B = 5, R3A = 6, R3B = 7
  } mat_reg_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [REG_W-1:0] pwdata = '0;
  logic [REG_W-1:0] prdata;
  logic pready;

  point_project_to_screen #(.FRAC_BITS(FRAC)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor's copy of the matrix registers
  logic [63:0] mat_shadow [NUM_REGS];
  out_word_t   screen_expect_q [$];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  hold_out = 1'b0;     // requests a long receiver hold-off
  int  hold_len = 0;
  bit  quiet_mode = 1'b0;   // no idling on either side

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [63:0] mat_entry(int r, int c);
    logic [63:0] w;
    w = mat_shadow[r*2 + c/2];
    return (c % 2) ? $signed(w[63:32]) : $signed(w[31:0]);
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1; return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1; return -64'sd2147483648;
    end
    return v;
  endfunction

  // exact row sum in 128 bits, round half up, floor
  function automatic logic signed [63:0] row_sum(int r, logic signed [63:0] px,
      logic signed [63:0] py, logic signed [63:0] pz);
    logic signed [127:0] acc;
    acc = mat_entry(r,0)*px + mat_entry(r,1)*py + mat_entry(r,2)*pz
        + (mat_entry(r,3) <<< FRAC) + (128'sd1 <<< (FRAC-1));
    acc = acc >>> FRAC;
    if (acc > 128'sd4294967296) return 64'sd4294967296;
    if (acc < -128'sd4294967296) return -64'sd4294967296;
    return acc[63:0];
  endfunction

  function automatic logic signed [63:0] half_ratio(logic signed [63:0] c,
      logic signed [63:0] w);
    logic [63:0] num, den, q;
    if (w == 0) return (c > 0) ? RATIO_CLAMP : ((c < 0) ? -RATIO_CLAMP : 64'sd0);
    num = (c < 0 ? -c : c) << FRAC;
    den = 2 * (w < 0 ? -w : w);
    q = (num + den/2) / den;
    if (q > RATIO_CLAMP) q = RATIO_CLAMP;
    return (c < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic out_word_t project_point(in_word_t p);
    logic signed [63:0] cl [4];
    logic signed [63:0] nx, ny, half, sx, sy;
    bit flag;
    out_word_t o;
    flag = 0;
    for (int r = 0; r < 4; r++)
      cl[r] = clamp32(row_sum(r, p.pos_x, p.pos_y, p.pos_z), flag);
    if (cl[3] == 0) flag = 1;
    half = 64'sd1 << (FRAC-1);
    nx = half_ratio(cl[0], cl[3]) + half;
    ny = half - half_ratio(cl[1], cl[3]);
    sx = clamp32(nx * $signed({48'd0, p.extent_x}) + (64'(p.offset_x) <<< FRAC), flag);
    sy = clamp32(ny * $signed({48'd0, p.extent_y}) + (64'(p.offset_y) <<< FRAC), flag);
    o.screen_x = sx[31:0];
    o.screen_y = sy[31:0];
    o.clip_z = cl[2][31:0];
    o.clip_w = cl[3][31:0];
    o.range_flag = flag;
    return o;
  endfunction

  // ------------------------------------------------------------ result check
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (screen_expect_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        fail_count++;
      end else begin
        exp_w = screen_expect_q.pop_front();
        if (out_data.screen_x !== exp_w.screen_x) begin
          $display("%0t: screen_x exp %h got %h", $time, exp_w.screen_x, out_data.screen_x);
          fail_count++;
        end
        if (out_data.screen_y !== exp_w.screen_y) begin
          $display("%0t: screen_y exp %h got %h", $time, exp_w.screen_y, out_data.screen_y);
          fail_count++;
        end
        if (out_data.clip_z !== exp_w.clip_z) begin
          $display("%0t: clip_z exp %h got %h", $time, exp_w.clip_z, out_data.clip_z);
          fail_count++;
        end
        if (out_data.clip_w !== exp_w.clip_w) begin
          $display("%0t: clip_w exp %h got %h", $time, exp_w.clip_w, out_data.clip_w);
          fail_count++;
        end
        if (out_data.range_flag !== exp_w.range_flag) begin
          $display("%0t: range_flag exp %b got %b", $time, exp_w.range_flag,
                   out_data.range_flag);
          fail_count++;
        end
      end
    end
  end

  // receiver stall: short random gaps, occasional long ones, a forced hold-off
  always @(posedge clk) begin
    int r;
    if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      out_stall <= 1'b1;
    end else if (hold_out) begin
      hold_out <= 1'b0;
      hold_len <= 300;
      out_stall <= 1'b1;
    end else if (quiet_mode) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        hold_len <= $urandom_range(10, 60);
        out_stall <= 1'b1;
      end else
        out_stall <= (r < 25);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ------------------------------------------------------------ shared tasks
  // valid stays high across back-to-back words; it drops only for a gap
  task automatic send_point(in_word_t p);
    int gap;
    gap = 0;
    if (!quiet_mode) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    screen_expect_q.push_back(project_point(p));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(mat_reg_e idx, logic [63:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_AW'(8 * int'(idx)); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mat_shadow[idx] = val;
    @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (screen_expect_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  function automatic in_word_t rand_point(bit narrow);
    in_word_t p;
    p.pos_x = narrow ? $signed($urandom_range(0, 1 << 24)) - (1 << 23) : $urandom;
    p.pos_y = narrow ? $signed($urandom_range(0, 1 << 24)) - (1 << 23) : $urandom;
    p.pos_z = narrow ? $signed($urandom_range(0, 1 << 24)) - (1 << 23) : $urandom;
    p.extent_x = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
    p.extent_y = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
    p.offset_x = 16'($urandom);
    p.offset_y = 16'($urandom);
    return p;
  endfunction

  function automatic logic [63:0] rand_pair;
    logic [31:0] a, b;
    a = ($urandom_range(0, 7) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    b = ($urandom_range(0, 7) == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
    return {b, a};
  endfunction

  // ------------------------------------------------------------ test tasks
  // Corner points under the reset matrix (rows 1-3 identity, row 0 only a raw 1 for y): w is 1.0.
  task automatic test_directed_corners;
    in_word_t p;
    logic [31:0] vals [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0001_0000,
                              32'hffff_0000, 32'h0000_8000};
    for (int i = 0; i < 6; i++) begin
      p = '{vals[i], vals[(i+1)%6], vals[(i+2)%6], 16'hffff, 16'h0,
            16'sh7fff, -16'sh8000};
      send_point(p);
    end
    p = '{32'h0, 32'h0, 32'h0, 16'd1920, 16'd1080, 16'sd0, 16'sd0};
    send_point(p);
    p = '{32'h0000_4000, -32'sh4000, 32'h1, 16'hffff, 16'hffff, -16'sh8000, 16'sh7fff};
    send_point(p);
    p = '{32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0};
    send_point(p);
  endtask

  // w = 0 (row 3 zeroed): saturation direction and zero extent.
  task automatic test_zero_w;
    in_word_t p;
    write_reg(R3A, 64'h0);
    write_reg(R3B, 64'h0);
    p = '{32'h0001_0000, -32'sh10000, 32'h5, 16'd640, 16'd480, 16'sd3, 16'sd4};
    send_point(p);
    p = '{-32'sh10000, 32'h0001_0000, 32'h5, 16'd640, 16'd480, 16'sd3, 16'sd4};
    send_point(p);
    p = '{32'h0, 32'h0, 32'h0, 16'd640, 16'd480, 16'sd3, 16'sd4};
    send_point(p);
    p = '{32'h0001_0000, 32'h0001_0000, 32'h0, 16'd0, 16'd0, -16'sd7, 16'sd9};
    send_point(p);
    drain();
  endtask

  // Perspective-like matrix with w = -z, plus extreme matrix entries.
  task automatic test_matrix_extremes;
    in_word_t p;
    write_reg(R0A, {32'h0, 32'h0001_8000});
    write_reg(R0B, {32'h0, 32'h0});
    write_reg(R1A, {32'h0002_0000, 32'h0});
    write_reg(R1B, 64'h0);
    write_reg(R2A, 64'h0);
    write_reg(R2B, {32'hffff_0000, 32'hfffe_0000});
    write_reg(R3A, 64'h0);
    write_reg(R3B, {32'h0, 32'hffff_0000});
    for (int i = 0; i < 4; i++) send_point(rand_point(1));
    drain();
    write_reg(R0A, 64'h7fff_ffff_8000_0000);
    write_reg(R0B, 64'hffff_ffff_ffff_ffff);
    write_reg(R3A, 64'h8000_0000_7fff_ffff);
    write_reg(R3B, 64'h0000_0000_8000_0000);
    for (int i = 0; i < 4; i++) send_point(rand_point(i[0]));
    drain();
  endtask

  // Random matrices and points with random idling.
  task automatic test_random_stream;
    for (int ph = 0; ph < 6; ph++) begin
      for (int r = 0; r < NUM_REGS; r++) write_reg(mat_reg_e'(r), rand_pair());
      for (int i = 0; i < 110; i++) send_point(rand_point($urandom_range(0, 3) != 0));
      drain();
    end
  endtask

  // Long output hold-off while points keep coming; then a gap-free burst.
  task automatic test_backpressure;
    hold_out = 1'b1;
    for (int i = 0; i < 80; i++) send_point(rand_point(1));
    drain();
    quiet_mode = 1'b1;
    for (int i = 0; i < 40; i++) send_point(rand_point(1));
    quiet_mode = 1'b0;
    drain();
  endtask

  initial begin
    for (int r = 0; r < NUM_REGS; r++) mat_shadow[r] = REG_RESET[r];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    drain();
    test_zero_w();
    test_matrix_extremes();
    test_random_stream();
    test_backpressure();
    if (fail_count == 0 && screen_expect_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
